// ===== rtl/mecanum_wheel_mixer_assert.svh =====
// Assertion macros for the mecanum wheel mixer.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef MECANUM_WHEEL_MIXER_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_ASSERT_SVH

// Same-cycle implication.
`define MWM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mecanum_wheel_mixer: assertion failed");

// Next-cycle implication.
`define MWM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mecanum_wheel_mixer: assertion failed");

`endif

// ===== rtl/mwm_pkg.sv =====
// Shared types, widths and constants of the mecanum wheel mixer.
// No dependencies.
package mwm_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 14;
  localparam int GUARD_BITS   = 16;
  localparam int CMD_W        = 16;
  localparam int XW           = CMD_W + GUARD_BITS + 4;  // cordic vector
  localparam int ZW           = 32;                      // binary angle
  localparam int SW           = 5;                       // cordic step index
  localparam int LO_W         = 18;                      // gain multiply split
  localparam int RW           = 20;                      // rotated component
  localparam int WW           = RW + 2;                  // wheel sum
  localparam int NW           = WW + FRAC_BITS;          // dividend
  localparam int DW           = NW + 1;                  // compare width
  localparam int QW           = FRAC_BITS + 1;           // quotient
  localparam int DIV_STEPS    = FRAC_BITS + 1;
  localparam int KW           = $clog2(DIV_STEPS);
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [CMD_W-1:0] forward_cmd;
    logic signed [CMD_W-1:0] strafe_cmd;
    logic signed [CMD_W-1:0] turn_cmd;
    logic signed [CMD_W-1:0] heading_angle;
  } cmd_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] front_left_power;
    logic signed [CMD_W-1:0] front_right_power;
    logic signed [CMD_W-1:0] back_left_power;
    logic signed [CMD_W-1:0] back_right_power;
  } wheel_t;

  // Side data that rides along the rotation chain.
  typedef struct packed {
    logic signed [CMD_W-1:0] fwd;
    logic signed [CMD_W-1:0] strafe;
    logic signed [CMD_W-1:0] turn;
    logic                    bypass;
  } side_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [ZW-1:0]        z;
    side_t                side;
  } cord_t;

  typedef struct packed {
    logic [WW-1:0]          m;
    logic [3:0][NW-1:0]     r;
    logic [3:0][QW-1:0]     q;
    logic [3:0]             neg;
  } div_t;

  function automatic logic [ZW-1:0] atan_val(input logic [SW-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/mwm_cordic_cell.sv =====
// One rotation step of the heading CORDIC, registered.
// Depends on mwm_pkg.
module mwm_cordic_cell (
  input  logic                  clk,
  input  logic                  en,
  input  logic [mwm_pkg::SW-1:0] step,
  input  mwm_pkg::cord_t        d,
  output mwm_pkg::cord_t        q
);

  logic signed [mwm_pkg::XW-1:0] dx;
  logic signed [mwm_pkg::XW-1:0] dy;
  logic [mwm_pkg::ZW-1:0]        ang;
  mwm_pkg::cord_t                q_next;

  always_comb begin
    dx     = d.y >>> step;
    dy     = d.x >>> step;
    ang    = mwm_pkg::atan_val(step);
    q_next = d;
    if (!d.z[mwm_pkg::ZW-1]) begin
      q_next.x = d.x - dx;
      q_next.y = d.y + dy;
      q_next.z = d.z - ang;
    end else begin
      q_next.x = d.x + dx;
      q_next.y = d.y - dy;
      q_next.z = d.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule

// ===== rtl/mwm_gain.sv =====
// CORDIC gain correction and rounding to Q5.14, two register stages.
// Depends on mwm_pkg.
module mwm_gain (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [mwm_pkg::XW-1:0] a,
  output logic signed [mwm_pkg::RW-1:0] res
);

  localparam int PW = 46 + mwm_pkg::RW;

  logic signed [30:0]                           g;
  logic signed [mwm_pkg::LO_W+31:0]             pl;
  logic signed [mwm_pkg::XW-mwm_pkg::LO_W+30:0] ph;
  logic signed [PW-1:0]                         p;

  assign g = $signed({1'b0, mwm_pkg::GAIN_Q30});

  always_ff @(posedge clk) begin
    if (en) begin
      pl <= $signed({1'b0, a[mwm_pkg::LO_W-1:0]}) * g;
      ph <= $signed(a[mwm_pkg::XW-1:mwm_pkg::LO_W]) * g;
    end
  end

  // round half up, then floor shift by 46
  assign p = (PW'(ph) <<< mwm_pkg::LO_W) + PW'(pl) + (PW'(1) <<< 45);

  always_ff @(posedge clk) begin
    if (en) res <= p[PW-1:46];
  end

endmodule

// ===== rtl/mwm_div_cell.sv =====
// One restoring-division step for all four wheel lanes, registered.
// Depends on mwm_pkg.
module mwm_div_cell (
  input  logic                   clk,
  input  logic                   en,
  input  logic [mwm_pkg::KW-1:0] k,
  input  mwm_pkg::div_t          d,
  output mwm_pkg::div_t          q
);

  logic [mwm_pkg::DW-1:0] dsh;
  mwm_pkg::div_t          q_next;

  always_comb begin
    dsh    = mwm_pkg::DW'(d.m) << k;
    q_next = d;
    for (int l = 0; l < 4; l++) begin
      if (mwm_pkg::DW'(d.r[l]) >= dsh) begin
        q_next.r[l]    = d.r[l] - dsh[mwm_pkg::NW-1:0];
        q_next.q[l][k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule

// ===== rtl/mecanum_wheel_mixer.sv =====
// Field-centric mecanum mixer top level: CORDIC chain, wheel sums, divider chain.
// Depends on mwm_pkg, mwm_cordic_cell, mwm_gain, mwm_div_cell, assert macros.
//
//  channel | valid       | stall       | payload
//  cmd     | cmd_valid   | cmd_stall   | cmd   (mwm_pkg::cmd_t)
//  wheel   | wheel_valid | wheel_stall | wheel (mwm_pkg::wheel_t)
//
// One beat per cycle while the output is not stalled; stages: entry register, rotation cells,
// gain registers, wheel sums, divider input register, one-bit-per-cell divider, output register.
// The whole pipeline holds while a finished beat is stalled at the output.
// rst clears the valid bits only; no state survives between beats.
`include "mecanum_wheel_mixer_assert.svh"
module mecanum_wheel_mixer (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  mwm_pkg::cmd_t   cmd,
  output logic            wheel_valid,
  input  logic            wheel_stall,
  output mwm_pkg::wheel_t wheel
);

  localparam int CS  = mwm_pkg::CORDIC_STEPS;
  localparam int DS  = mwm_pkg::DIV_STEPS;
  localparam int L   = CS + DS + 6;
  localparam int GA  = CS + 2;   // gain output
  localparam int DI  = CS + 4;   // divider input

  logic [L-1:0] vp;
  logic         adv;

  assign adv         = !vp[L-1] || !wheel_stall;
  assign cmd_stall   = !adv;
  assign wheel_valid = vp[L-1];

  always_ff @(posedge clk) begin
    if (rst) vp <= '0;
    else if (adv) vp <= {vp[L-2:0], cmd_valid};
  end

  // entry: scale, negate heading, fold into +-90 degrees
  mwm_pkg::cord_t cs [0:CS];
  mwm_pkg::cord_t c0_next;
  logic [mwm_pkg::ZW-1:0] z0;

  always_comb begin
    z0                    = '0 - {cmd.heading_angle, 16'h0000};
    c0_next.x             = mwm_pkg::XW'(cmd.strafe_cmd) <<< mwm_pkg::GUARD_BITS;
    c0_next.y             = mwm_pkg::XW'(cmd.forward_cmd) <<< mwm_pkg::GUARD_BITS;
    c0_next.z             = z0;
    c0_next.side.fwd      = cmd.forward_cmd;
    c0_next.side.strafe   = cmd.strafe_cmd;
    c0_next.side.turn     = cmd.turn_cmd;
    c0_next.side.bypass   = (cmd.heading_angle == '0);
    if (z0[31:30] == 2'b01 || z0[31:30] == 2'b10) begin
      c0_next.x = -c0_next.x;
      c0_next.y = -c0_next.y;
      c0_next.z = z0 + 32'h8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) cs[0] <= c0_next;
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    mwm_cordic_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .step (mwm_pkg::SW'(i)),
      .d    (cs[i]),
      .q    (cs[i+1])
    );
  end

  logic signed [mwm_pkg::RW-1:0] rx;
  logic signed [mwm_pkg::RW-1:0] ry;
  mwm_pkg::side_t                sd1;
  mwm_pkg::side_t                sd2;

  mwm_gain u_gain_x (.clk(clk), .en(adv), .a(cs[CS].x), .res(rx));
  mwm_gain u_gain_y (.clk(clk), .en(adv), .a(cs[CS].y), .res(ry));

  always_ff @(posedge clk) begin
    if (adv) begin
      sd1 <= cs[CS].side;
      sd2 <= sd1;
    end
  end

  // wheel sums
  logic signed [mwm_pkg::RW-1:0] ux;
  logic signed [mwm_pkg::RW-1:0] uy;
  logic signed [mwm_pkg::WW-1:0] ut;
  logic signed [mwm_pkg::WW-1:0] w [4];

  assign ux = sd2.bypass ? mwm_pkg::RW'(sd2.strafe) : rx;
  assign uy = sd2.bypass ? mwm_pkg::RW'(sd2.fwd) : ry;
  assign ut = mwm_pkg::WW'(sd2.turn);

  always_ff @(posedge clk) begin
    if (adv) begin
      w[0] <= mwm_pkg::WW'(uy) + mwm_pkg::WW'(ux) + ut;
      w[1] <= mwm_pkg::WW'(uy) - mwm_pkg::WW'(ux) - ut;
      w[2] <= mwm_pkg::WW'(uy) - mwm_pkg::WW'(ux) + ut;
      w[3] <= mwm_pkg::WW'(uy) + mwm_pkg::WW'(ux) - ut;
    end
  end

  // max magnitude; a divisor of 1.0 passes the sums through unchanged
  logic [mwm_pkg::WW-1:0] aw [4];
  logic [mwm_pkg::WW-1:0] m01;
  logic [mwm_pkg::WW-1:0] m23;
  logic [mwm_pkg::WW-1:0] mx;
  mwm_pkg::div_t          dv [0:DS];
  mwm_pkg::div_t          d0_next;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      aw[l] = w[l][mwm_pkg::WW-1] ? mwm_pkg::WW'(-w[l]) : mwm_pkg::WW'(w[l]);
    end
    m01       = (aw[0] > aw[1]) ? aw[0] : aw[1];
    m23       = (aw[2] > aw[3]) ? aw[2] : aw[3];
    mx        = (m01 > m23) ? m01 : m23;
    d0_next.m = (mx > mwm_pkg::ONE) ? mx : mwm_pkg::ONE;
    for (int l = 0; l < 4; l++) begin
      d0_next.r[l]   = mwm_pkg::NW'(aw[l]) << mwm_pkg::FRAC_BITS;
      d0_next.q[l]   = '0;
      d0_next.neg[l] = w[l][mwm_pkg::WW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) dv[0] <= d0_next;
  end

  for (genvar i = 0; i < DS; i++) begin : g_div
    mwm_div_cell u_cell (
      .clk (clk),
      .en  (adv),
      .k   (mwm_pkg::KW'(DS - 1 - i)),
      .d   (dv[i]),
      .q   (dv[i+1])
    );
  end

  logic signed [mwm_pkg::CMD_W-1:0] pw [4];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      pw[l] = dv[DS].neg[l] ? -mwm_pkg::CMD_W'(dv[DS].q[l])
                            : mwm_pkg::CMD_W'(dv[DS].q[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wheel.front_left_power  <= pw[0];
      wheel.front_right_power <= pw[1];
      wheel.back_left_power   <= pw[2];
      wheel.back_right_power  <= pw[3];
    end
  end

  // divisor is at least 1.0 and never below lane 0's magnitude
  `MWM_ASSERT_IMP(a_div_bound, vp[DI], (dv[0].m >= mwm_pkg::ONE) && (dv[0].r[0] <= (mwm_pkg::NW'(dv[0].m) << mwm_pkg::FRAC_BITS)))
  // front-left and back-right results lie within +-1.0
  `MWM_ASSERT_IMP(a_out_range, wheel_valid, ($signed(wheel.front_left_power) <= 16384) && ($signed(wheel.front_left_power) >= -16384) && ($signed(wheel.back_right_power) <= 16384) && ($signed(wheel.back_right_power) >= -16384))
  // a held pipeline neither gains nor loses beats
  `MWM_ASSERT_NXT(a_hold, !adv && !rst, $countones(vp) == $countones($past(vp)))

endmodule

// ===== dv/tb.sv =====
// Testbench for mecanum_wheel_mixer: drives random and directed drive commands,
// predicts wheel powers with a bit-exact CORDIC/normalize model, checks in order.
// Depends on mwm_pkg and the mecanum_wheel_mixer RTL.
`timescale 1ns / 1ps

class wheel_scoreboard;
  mwm_pkg::wheel_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // Rotate (x, y) by minus the heading; x = strafe, y = forward.
  static function void rotate_vec(ref longint x, ref longint y, input logic [15:0] hdg);
    logic [31:0] z;
    longint dx, dy;
    logic [31:0] atan_tab [24];
    atan_tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
                 32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
                 32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
                 32'd166886, 32'd83443, 32'd41722, 32'd20861,
                 32'd10430, 32'd5215, 32'd2608, 32'd1304,
                 32'd652, 32'd326, 32'd163, 32'd81};
    x = x * 65536;
    y = y * 65536;
    z = 32'd0 - {hdg, 16'd0};
    if (z[31:30] == 2'd1 || z[31:30] == 2'd2) begin
      x = -x;
      y = -y;
      z = z + 32'h8000_0000;
    end
    for (int i = 0; i < mwm_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (!z[31]) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end
    end
    x = floor_shr(x * 64'sd652032874 + (64'sd1 <<< 45), 46);
    y = floor_shr(y * 64'sd652032874 + (64'sd1 <<< 45), 46);
  endfunction

  static function mwm_pkg::wheel_t mix_wheels(mwm_pkg::cmd_t c);
    longint x, y, t, m, one;
    longint w[4];
    mwm_pkg::wheel_t r;
    y = longint'(c.forward_cmd);
    x = longint'(c.strafe_cmd);
    t = longint'(c.turn_cmd);
    one = 64'sd1 <<< mwm_pkg::FRAC_BITS;
    if (c.heading_angle != 0) rotate_vec(x, y, c.heading_angle);
    w[0] = y + x + t;
    w[1] = y - x - t;
    w[2] = y - x + t;
    w[3] = y + x - t;
    m = 0;
    foreach (w[k]) if ((w[k] < 0 ? -w[k] : w[k]) > m) m = (w[k] < 0 ? -w[k] : w[k]);
    if (m > one) foreach (w[k]) w[k] = (w[k] * one) / m;
    r.front_left_power  = w[0][15:0];
    r.front_right_power = w[1][15:0];
    r.back_left_power   = w[2][15:0];
    r.back_right_power  = w[3][15:0];
    return r;
  endfunction

  function void note_cmd(mwm_pkg::cmd_t c);
    pending.push_back(mix_wheels(c));
  endfunction

  function void check_wheel(mwm_pkg::wheel_t got);
    mwm_pkg::wheel_t exp_w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected wheel beat %h", $time, got);
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    if (got.front_left_power != exp_w.front_left_power) begin
      $display("%0t: front_left exp %0d got %0d", $time,
               exp_w.front_left_power, got.front_left_power);
      errors++;
    end
    if (got.front_right_power != exp_w.front_right_power) begin
      $display("%0t: front_right exp %0d got %0d", $time,
               exp_w.front_right_power, got.front_right_power);
      errors++;
    end
    if (got.back_left_power != exp_w.back_left_power) begin
      $display("%0t: back_left exp %0d got %0d", $time,
               exp_w.back_left_power, got.back_left_power);
      errors++;
    end
    if (got.back_right_power != exp_w.back_right_power) begin
      $display("%0t: back_right exp %0d got %0d", $time,
               exp_w.back_right_power, got.back_right_power);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int LATENCY = mwm_pkg::CORDIC_STEPS + mwm_pkg::DIV_STEPS + 6;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  mwm_pkg::cmd_t cmd = '0;
  logic wheel_valid;
  logic wheel_stall = 1'b0;
  mwm_pkg::wheel_t wheel;

  wheel_scoreboard sb = new();
  longint cycles = 0;
  bit stall_quiet = 1'b0;

  mecanum_wheel_mixer uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .wheel_valid(wheel_valid), .wheel_stall(wheel_stall), .wheel(wheel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Mostly within +-1.0, else an extreme, zero or anything in 16 bits.
  function automatic logic [15:0] rand_stick();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 16'($signed($urandom_range(0, 32768)) - 16384);
    if (p < 80) return 16'($urandom());
    case ($urandom_range(0, 4))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'h7fff;
      3: return 16'h8000;
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] rand_heading();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'd0;
    if (p == 1) return 16'($urandom_range(0, 7)) << 13;  // multiples of 45 deg
    if (p == 2) return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 4)) - 16'd2;
    return 16'($urandom());
  endfunction

  // valid stays high across back-to-back beats; dropped only for a gap
  task automatic send_cmd(mwm_pkg::cmd_t c);
    int g;
    g = gap_len();
    if (g != 0) begin
      cmd_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_cmd(c);
  endtask

  task automatic send_fields(logic [15:0] f, logic [15:0] s, logic [15:0] t, logic [15:0] h);
    mwm_pkg::cmd_t c;
    c.forward_cmd = f;
    c.strafe_cmd = s;
    c.turn_cmd = t;
    c.heading_angle = h;
    send_cmd(c);
  endtask

  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Output side: random stall, checks accepted beats.
  always @(posedge clk) begin
    if (!rst && wheel_valid && !wheel_stall) sb.check_wheel(wheel);
    if (stall_quiet) wheel_stall <= 1'b0;
    else wheel_stall <= (gap_len() != 0) && ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero heading, quadrant edges, normalization
    send_fields(16'sd16384, 16'sd0, 16'sd0, 16'd0);
    send_fields(-16'sd16384, -16'sd16384, -16'sd16384, 16'd0);
    send_fields(16'sd16384, 16'sd16384, 16'sd16384, 16'd0);
    send_fields(16'h7fff, 16'h8000, 16'h7fff, 16'd0);
    send_fields(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_fields(16'sd0, 16'sd0, 16'sd0, 16'h1234);
    send_fields(16'sd16384, 16'sd0, 16'sd0, 16'h4000);
    send_fields(16'sd16384, 16'sd0, 16'sd0, 16'hc000);
    send_fields(16'sd16384, 16'sd0, 16'sd0, 16'h4001);
    send_fields(16'sd16384, 16'sd0, 16'sd0, 16'h3fff);
    send_fields(16'sd16384, 16'sd0, 16'sd0, 16'h8000);
    send_fields(16'sd0, 16'sd16384, 16'sd0, 16'h7fff);
    send_fields(16'sd0, 16'sd16384, 16'sd0, 16'hbfff);
    send_fields(16'sd8192, 16'sd8192, 16'sd0, 16'h2000);
    send_fields(16'sd16384, 16'sd16384, 16'sd0, 16'hffff);
    send_fields(16'sd16384, 16'sd0, 16'sd1, 16'd0);
    send_fields(16'sd16383, 16'sd1, 16'sd0, 16'd0);
    send_fields(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_fields(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_fields(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);

    // hold off until the pipeline is empty
    drain_results();
    repeat (5) @(posedge clk);

    for (int n = 0; n < 1950; n++) begin
      send_fields(rand_stick(), rand_stick(), rand_stick(), rand_heading());
      if (n == 900) begin
        drain_results();
        stall_quiet = 1'b1;
      end
      if (n == 1300) stall_quiet = 1'b0;
    end

    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/mwm_pkg.sv
rtl/mwm_cordic_cell.sv
rtl/mwm_gain.sv
rtl/mwm_div_cell.sv
rtl/mecanum_wheel_mixer.sv
dv/tb.sv
